>>> hw/rtl/pidc_pkg.sv
package pidc_pkg;

  // configuration port
  localparam int ADDR_W = 5;

  typedef enum logic [2:0] {
    REG_LOOP_ENABLE  = 3'd0,
    REG_GAIN_P       = 3'd1,
    REG_GAIN_I       = 3'd2,
    REG_GAIN_D       = 3'd3,
    REG_OUTPUT_LIMIT = 3'd4
  } reg_index_t;

  // arithmetic constants
  localparam int          DIV_QBITS    = 62;
  localparam int          DIV_STEPS    = DIV_QBITS / 2;
  localparam int          DIV_CNT_W    = $clog2(DIV_STEPS);
  localparam logic [60:0] TERM_LIM     = {1'b1, 60'd0};
  localparam logic [47:0] TRAP_DIVISOR = 48'd2000000;
  localparam logic [95:0] TRAP_HALF    = 96'd1000000;
  localparam logic [31:0] US_PER_S     = 32'd1000000;
  localparam logic [95:0] ROUND_Q16    = 96'd32768;

  // payload words
  typedef struct packed {
    logic signed [31:0] setpoint;
    logic signed [31:0] measurement;
    logic        [31:0] elapsed_us;
    logic               clear_state;
  } sample_t;

  typedef struct packed {
    logic signed [31:0] drive;
    logic               updated;
    logic               clamped;
  } result_t;

  typedef struct packed {
    logic               loop_enable;
    logic signed [31:0] gain_p;
    logic signed [31:0] gain_i;
    logic signed [31:0] gain_d;
    logic        [30:0] output_limit;
  } cfg_t;

  // shared unit handshakes
  typedef struct packed {
    logic        start;
    logic [63:0] x;
    logic [31:0] y;
  } mul_req_t;

  typedef struct packed {
    logic        done;
    logic [95:0] prod;
  } mul_rsp_t;

  typedef struct packed {
    logic        start;
    logic [95:0] dividend;
    logic [47:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [60:0] quotient;
  } div_rsp_t;

  // state machines
  typedef enum logic [1:0] {
    MUL_IDLE,
    MUL_LOW,
    MUL_HIGH
  } mul_phase_t;

  typedef enum logic {
    DIV_IDLE,
    DIV_RUN
  } div_state_t;

  typedef enum logic [4:0] {
    C_IDLE,
    C_GATE_GO,
    C_GATE_WAIT,
    C_TRAP_GO,
    C_TRAP_WAIT,
    C_TDIV_GO,
    C_TDIV_WAIT,
    C_PROP_GO,
    C_PROP_WAIT,
    C_INTG_GO,
    C_INTG_WAIT,
    C_DER1_GO,
    C_DER1_WAIT,
    C_DER2_GO,
    C_DER2_WAIT,
    C_DDIV_GO,
    C_DDIV_WAIT,
    C_CLAMP,
    C_FINISH
  } core_state_t;

endpackage

>>> hw/rtl/pidc_regs.sv
module pidc_regs
  import pidc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (paddr[ADDR_W-1:2])
        REG_LOOP_ENABLE:  cfg.loop_enable  <= pwdata[0];
        REG_GAIN_P:       cfg.gain_p       <= pwdata;
        REG_GAIN_I:       cfg.gain_i       <= pwdata;
        REG_GAIN_D:       cfg.gain_d       <= pwdata;
        REG_OUTPUT_LIMIT: cfg.output_limit <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (paddr[ADDR_W-1:2])
      REG_LOOP_ENABLE:  prdata = {31'd0, cfg.loop_enable};
      REG_GAIN_P:       prdata = cfg.gain_p;
      REG_GAIN_I:       prdata = cfg.gain_i;
      REG_GAIN_D:       prdata = cfg.gain_d;
      REG_OUTPUT_LIMIT: prdata = {1'b0, cfg.output_limit};
      default:          prdata = '0;
    endcase
  end

endmodule

>>> hw/rtl/pidc_mul.sv
module pidc_mul
  import pidc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  mul_phase_t  phase, phase_next;
  logic [63:0] pp;
  logic [31:0] x_hi;
  logic [31:0] y_hold;
  logic [95:0] acc;
  logic        done;

  assign rsp.done = done;
  assign rsp.prod = acc;

  // phase sequencing: low half product, then high half product
  always_comb begin
    phase_next = phase;
    case (phase)
      MUL_IDLE: if (req.start) phase_next = MUL_LOW;
      MUL_LOW:  phase_next = MUL_HIGH;
      MUL_HIGH: phase_next = MUL_IDLE;
      default:  phase_next = MUL_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= MUL_IDLE;
      done  <= 1'b0;
    end else begin
      phase <= phase_next;
      done  <= (phase == MUL_HIGH);
    end
  end

  // 32x32 multiplier, registered, then accumulate
  always_ff @(posedge clk) begin
    case (phase)
      MUL_IDLE: begin
        if (req.start) begin
          pp     <= req.x[31:0] * req.y;
          x_hi   <= req.x[63:32];
          y_hold <= req.y;
        end
      end
      MUL_LOW: begin
        acc <= {32'd0, pp};
        pp  <= x_hi * y_hold;
      end
      MUL_HIGH: acc <= acc + {pp, 32'd0};
      default: ;
    endcase
  end

endmodule

>>> hw/rtl/pidc_div.sv
module pidc_div
  import pidc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  div_state_t           state, state_next;
  logic [47:0]          divisor;
  logic [47:0]          rem;
  logic [DIV_QBITS-1:0] low;
  logic [DIV_QBITS-1:0] quo;
  logic [DIV_QBITS-1:0] quo_next;
  logic [DIV_CNT_W-1:0] cnt;
  logic [60:0]          res;
  logic                 done;
  logic                 ovf;
  logic                 last;
  logic [48:0]          r1a, r2a;
  logic [47:0]          r1, r2;
  logic                 b1, b0;

  assign rsp.done     = done;
  assign rsp.quotient = res;

  // quotient would reach 2^62 or more: saturate at once
  assign ovf  = 48'(req.dividend[95:DIV_QBITS]) >= req.divisor;
  assign last = (cnt == DIV_CNT_W'(DIV_STEPS - 1));

  // two restoring steps per cycle
  always_comb begin
    r1a      = {rem, low[DIV_QBITS-1]};
    b1       = r1a >= {1'b0, divisor};
    r1       = b1 ? 48'(r1a - {1'b0, divisor}) : r1a[47:0];
    r2a      = {r1, low[DIV_QBITS-2]};
    b0       = r2a >= {1'b0, divisor};
    r2       = b0 ? 48'(r2a - {1'b0, divisor}) : r2a[47:0];
    quo_next = {quo[DIV_QBITS-3:0], b1, b0};
  end

  always_comb begin
    state_next = state;
    case (state)
      DIV_IDLE: if (req.start && !ovf) state_next = DIV_RUN;
      DIV_RUN:  if (last) state_next = DIV_IDLE;
      default:  state_next = DIV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DIV_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= ((state == DIV_IDLE) && req.start && ovf) || ((state == DIV_RUN) && last);
    end
  end

  // remainder, dividend bits and quotient
  always_ff @(posedge clk) begin
    case (state)
      DIV_IDLE: begin
        if (req.start) begin
          rem     <= 48'(req.dividend[95:DIV_QBITS]);
          low     <= req.dividend[DIV_QBITS-1:0];
          quo     <= '0;
          cnt     <= '0;
          divisor <= req.divisor;
          if (ovf) res <= TERM_LIM;
        end
      end
      DIV_RUN: begin
        rem <= r2;
        low <= {low[DIV_QBITS-3:0], 2'b00};
        quo <= quo_next;
        cnt <= cnt + DIV_CNT_W'(1);
        if (last) res <= (quo_next > DIV_QBITS'(TERM_LIM)) ? TERM_LIM : quo_next[60:0];
      end
      default: ;
    endcase
  end

endmodule

>>> hw/rtl/pidc_core.sv
module pidc_core
  import pidc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg,
  input  logic     sample_valid,
  output logic     sample_ready,
  input  sample_t  sample,
  output logic     result_valid,
  input  logic     result_ready,
  output result_t  result,
  output mul_req_t mul_req,
  input  mul_rsp_t mul_rsp,
  output div_req_t div_req,
  input  div_rsp_t div_rsp
);

  core_state_t        state, state_next;
  logic signed [32:0] err_r, prev_r;
  logic        [31:0] us_r;
  logic signed [31:0] meas_r;
  logic signed [31:0] last_meas;
  logic signed [47:0] integ;
  logic signed [62:0] sum;
  result_t            res;
  result_t            out;
  logic               out_valid;

  logic               accept, skip, slot_free, load_out, gate;
  logic signed [33:0] esum, diff;
  logic        [63:0] mag_integ, mag_esum, mag_err, mag_diff;
  logic        [31:0] mag_gp, mag_gi, mag_gd;
  logic               neg_trap, neg_p, neg_i, neg_d;
  logic        [60:0] tq;
  logic signed [62:0] integ_sum;
  logic signed [47:0] integ_sat;
  logic signed [62:0] lim_s, neg_lim;
  logic signed [31:0] drive_c;
  logic               clamp_c;

  function automatic logic [63:0] mag64(input logic [63:0] v);
    return v[63] ? 64'd0 - v : v;
  endfunction

  // round a Q.32 product to Q.16, ties away from zero, saturated
  function automatic logic [60:0] round_q16(input logic [95:0] p);
    logic [95:0] t;
    t = p + ROUND_Q16;
    if (t[95:16] > 80'(TERM_LIM)) return TERM_LIM;
    return t[76:16];
  endfunction

  function automatic logic signed [62:0] apply_sign(input logic neg, input logic [60:0] q);
    logic signed [62:0] q_ext;
    q_ext = {2'b00, q};
    return neg ? -q_ext : q_ext;
  endfunction

  assign result       = out;
  assign result_valid = out_valid;
  assign accept       = sample_valid && sample_ready;
  assign skip         = !cfg.loop_enable || sample.clear_state;
  assign slot_free    = !out_valid || result_ready;
  assign load_out     = (state == C_FINISH) && slot_free;

  // operand magnitudes and term signs
  assign esum      = {err_r[32], err_r} + {prev_r[32], prev_r};
  assign diff      = {err_r[32], err_r} - {prev_r[32], prev_r};
  assign mag_integ = mag64({{16{integ[47]}}, integ});
  assign mag_esum  = mag64({{30{esum[33]}}, esum});
  assign mag_err   = mag64({{31{err_r[32]}}, err_r});
  assign mag_diff  = mag64({{30{diff[33]}}, diff});
  assign mag_gp    = 32'(mag64({{32{cfg.gain_p[31]}}, cfg.gain_p}));
  assign mag_gi    = 32'(mag64({{32{cfg.gain_i[31]}}, cfg.gain_i}));
  assign mag_gd    = 32'(mag64({{32{cfg.gain_d[31]}}, cfg.gain_d}));
  assign neg_trap  = esum[33];
  assign neg_p     = err_r[32] ^ cfg.gain_p[31];
  assign neg_i     = integ[47] ^ cfg.gain_i[31];
  assign neg_d     = diff[33] ^ cfg.gain_d[31];
  assign tq        = round_q16(mul_rsp.prod);

  // integrate while |integral| * gain_i stays below the limit, or while gain_i < 0 and integral != 0
  assign gate = (cfg.gain_i[31] && (integ != '0)) ||
                ((mul_rsp.prod[95:47] == '0) &&
                 (mul_rsp.prod[46:0] < {cfg.output_limit, 16'd0}));

  // integral update with 48 bit saturation
  always_comb begin
    integ_sum = {{15{integ[47]}}, integ} + apply_sign(neg_trap, div_rsp.quotient);
    if (integ_sum[62:47] == {16{integ_sum[47]}}) begin
      integ_sat = integ_sum[47:0];
    end else if (integ_sum[62]) begin
      integ_sat = {1'b1, 47'd0};
    end else begin
      integ_sat = {1'b0, {47{1'b1}}};
    end
  end

  // output clamp
  assign lim_s   = {32'd0, cfg.output_limit};
  assign neg_lim = -lim_s;

  always_comb begin
    clamp_c = 1'b0;
    drive_c = sum[31:0];
    if (sum > lim_s) begin
      drive_c = {1'b0, cfg.output_limit};
      clamp_c = 1'b1;
    end else if (sum < neg_lim) begin
      drive_c = neg_lim[31:0];
      clamp_c = 1'b1;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    sample_ready = 1'b0;
    mul_req      = '0;
    div_req      = '0;
    case (state)
      C_IDLE: begin
        sample_ready = 1'b1;
        if (sample_valid) state_next = skip ? C_FINISH : C_GATE_GO;
      end
      C_GATE_GO: begin
        mul_req    = '{start: 1'b1, x: mag_integ, y: mag_gi};
        state_next = C_GATE_WAIT;
      end
      C_GATE_WAIT: if (mul_rsp.done) state_next = gate ? C_TRAP_GO : C_PROP_GO;
      C_TRAP_GO: begin
        mul_req    = '{start: 1'b1, x: mag_esum, y: us_r};
        state_next = C_TRAP_WAIT;
      end
      C_TRAP_WAIT: if (mul_rsp.done) state_next = C_TDIV_GO;
      C_TDIV_GO: begin
        div_req    = '{start: 1'b1, dividend: mul_rsp.prod + TRAP_HALF,
                       divisor: TRAP_DIVISOR};
        state_next = C_TDIV_WAIT;
      end
      C_TDIV_WAIT: if (div_rsp.done) state_next = C_PROP_GO;
      C_PROP_GO: begin
        mul_req    = '{start: 1'b1, x: mag_err, y: mag_gp};
        state_next = C_PROP_WAIT;
      end
      C_PROP_WAIT: if (mul_rsp.done) state_next = C_INTG_GO;
      C_INTG_GO: begin
        mul_req    = '{start: 1'b1, x: mag_integ, y: mag_gi};
        state_next = C_INTG_WAIT;
      end
      C_INTG_WAIT: if (mul_rsp.done) state_next = (us_r != '0) ? C_DER1_GO : C_CLAMP;
      C_DER1_GO: begin
        mul_req    = '{start: 1'b1, x: mag_diff, y: US_PER_S};
        state_next = C_DER1_WAIT;
      end
      C_DER1_WAIT: if (mul_rsp.done) state_next = C_DER2_GO;
      C_DER2_GO: begin
        mul_req    = '{start: 1'b1, x: mul_rsp.prod[63:0], y: mag_gd};
        state_next = C_DER2_WAIT;
      end
      C_DER2_WAIT: if (mul_rsp.done) state_next = C_DDIV_GO;
      C_DDIV_GO: begin
        div_req    = '{start: 1'b1, dividend: mul_rsp.prod + {49'd0, us_r, 15'd0},
                       divisor: {us_r, 16'd0}};
        state_next = C_DDIV_WAIT;
      end
      C_DDIV_WAIT: if (div_rsp.done) state_next = C_CLAMP;
      C_CLAMP:  state_next = C_FINISH;
      C_FINISH: if (slot_free) state_next = C_IDLE;
      default:  state_next = C_IDLE;
    endcase
  end

  // controller state, working registers and output word
  always_ff @(posedge clk) begin
    if (rst) begin
      last_meas <= '0;
      integ     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        if (skip) begin
          last_meas <= '0;
          integ     <= '0;
          res       <= '0;
        end else begin
          err_r  <= {sample.setpoint[31], sample.setpoint} -
                    {sample.measurement[31], sample.measurement};
          prev_r <= {sample.setpoint[31], sample.setpoint} - {last_meas[31], last_meas};
          us_r   <= sample.elapsed_us;
          meas_r <= sample.measurement;
        end
      end
      case (state)
        C_TDIV_WAIT: if (div_rsp.done) integ <= integ_sat;
        C_PROP_WAIT: if (mul_rsp.done) sum <= apply_sign(neg_p, tq);
        C_INTG_WAIT: if (mul_rsp.done) sum <= sum + apply_sign(neg_i, tq);
        C_DDIV_WAIT: if (div_rsp.done) sum <= sum + apply_sign(neg_d, div_rsp.quotient);
        C_CLAMP: begin
          res       <= '{drive: drive_c, updated: 1'b1, clamped: clamp_c};
          last_meas <= meas_r;
        end
        default: ;
      endcase
      if (load_out) begin
        out       <= res;
        out_valid <= 1'b1;
      end else if (result_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> hw/rtl/pid_controller_trapezoid_antiwindup.sv
// an enabled word runs the gate product, then the trapezoid product and divide when the
// integral is updated, the proportional and integral products, and the derivative products
// and divide when elapsed_us is nonzero (the divide ends at once when the derivative term
// saturates in the divider); a cleared word goes straight to the output; one word at a time
// through the shared 32x32 multiplier and the shared divider (2 quotient bits a cycle)
// reset: synchronous rst zeroes configuration registers, integral and stored measurement; loop disabled
module pid_controller_trapezoid_antiwindup
  import pidc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              sample_valid,
  output logic              sample_ready,
  input  sample_t           sample,
  output logic              result_valid,
  input  logic              result_ready,
  output result_t           result
);

  cfg_t     cfg;
  mul_req_t mul_req;
  mul_rsp_t mul_rsp;
  div_req_t div_req;
  div_rsp_t div_rsp;

  // configuration registers
  pidc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sequencer and controller state
  pidc_core u_core (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .mul_req      (mul_req),
    .mul_rsp      (mul_rsp),
    .div_req      (div_req),
    .div_rsp      (div_rsp)
  );

  // shared multiplier
  pidc_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  // shared divider
  pidc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

endmodule

>>> hw/rtl/pidc_checker.sv
module pidc_checker
  import pidc_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    sample_valid,
  input logic    sample_ready,
  input sample_t sample,
  input logic    result_valid,
  input logic    result_ready,
  input result_t result
);

  // a stalled result word holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result word changed while stalled");

  // one word at a time: not ready right after an acceptance
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_ready |=> !sample_ready)
    else $error("ready right after accepting a word");

  // a cleared word accepted while the output is empty gives a zero result through C_FINISH
  a_clear_result: assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_ready && sample.clear_state && !result_valid |->
      ##2 (result_valid && !result.updated && (result.drive == '0) && !result.clamped))
    else $error("cleared word did not give a zero result");

  // after reset the block is empty and ready
  a_reset_state: assert property (@(posedge clk)
    rst |=> sample_ready && !result_valid)
    else $error("block not empty after reset");

endmodule

bind pid_controller_trapezoid_antiwindup pidc_checker u_checker (.*);

>>> dv/tb_pid_controller_trapezoid_antiwindup.sv
`timescale 1ns / 1ps

module tb_pid_controller_trapezoid_antiwindup;
  import pidc_pkg::*;

  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          DRAIN_CYCLES   = 120;
  localparam int          PHASES         = 6;
  localparam int          PHASE_WORDS    = 72;
  localparam longint      INTEG_MAX      = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint      INTEG_MIN      = -64'sh0000_8000_0000_0000;
  localparam logic [63:0] TERM_CAP       = 64'd1 << 60;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              sample_valid = 1'b0;
  logic              sample_ready;
  sample_t           sample = '0;
  logic              result_valid;
  logic              result_ready = 1'b0;
  result_t           result;

  // words waiting to be sent and results still owed by the block
  sample_t pending_words[$];
  result_t drive_expect[$];
  result_t head_r;

  // predictor copy of registers and controller state
  cfg_t   ctl = '0;
  longint held_meas = 0;
  longint integ_acc = 0;

  int          fail_count = 0;
  int          send_wait = 0;
  int          take_wait = 0;
  int          quiet_cycles = 0;
  logic        send_burst = 1'b0;
  logic        take_burst = 1'b0;
  int          plant_target = 0;
  int          plant_level = 0;
  logic [31:0] elapsed_pick;
  logic [30:0] limit_draw;

  pid_controller_trapezoid_antiwindup dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always #6 clk = ~clk;

  // round(a * b * c / d) with ties away from zero, capped at 2^60 in magnitude
  function automatic longint scaled_term(longint a, longint b, logic [31:0] c, logic [63:0] d);
    logic         neg;
    logic [63:0]  ma;
    logic [63:0]  mb;
    logic [127:0] num;
    logic [127:0] quo;
    neg = (a < 0) != (b < 0);
    ma  = (a < 0) ? 64'(-a) : 64'(a);
    mb  = (b < 0) ? 64'(-b) : 64'(b);
    num = ma * mb * c + (d >> 1);
    quo = num / d;
    if (quo > 128'(TERM_CAP)) quo = 128'(TERM_CAP);
    return neg ? -longint'(quo[63:0]) : longint'(quo[63:0]);
  endfunction

  // one control step: integral gate, trapezoid, three terms, clamp
  function automatic result_t compute_step(sample_t w);
    result_t     r;
    longint      sp;
    longint      meas;
    longint      us;
    longint      err;
    longint      prev;
    longint      sum;
    longint      lim;
    longint      ni;
    longint      gi;
    logic [63:0] absi;
    logic [63:0] lim_q;
    logic        gate;
    r = '0;
    if (!ctl.loop_enable || w.clear_state) begin
      held_meas = 0;
      integ_acc = 0;
      return r;
    end
    sp   = longint'($signed(w.setpoint));
    meas = longint'($signed(w.measurement));
    us   = longint'({32'd0, w.elapsed_us});
    lim  = longint'({33'd0, ctl.output_limit});
    err  = sp - meas;
    prev = sp - held_meas;

    // integrate while |integral| * gain_i stays below the limit, or while gain_i < 0 and integral != 0
    absi  = (integ_acc < 0) ? 64'(-integ_acc) : 64'(integ_acc);
    lim_q = 64'(ctl.output_limit) << 16;
    gi    = longint'($signed(ctl.gain_i));
    if (gi > 0) gate = (lim_q != 0) && (absi <= (lim_q - 1) / 64'(gi));
    else if (gi == 0 || absi == 0) gate = lim_q != 0;
    else gate = 1'b1;
    if (gate) begin
      ni = integ_acc + scaled_term(err + prev, us, 32'd1, 64'd2000000);
      if (ni > INTEG_MAX) ni = INTEG_MAX;
      if (ni < INTEG_MIN) ni = INTEG_MIN;
      integ_acc = ni;
    end

    sum = scaled_term(longint'($signed(ctl.gain_p)), err, 32'd1, 64'd65536)
        + scaled_term(gi, integ_acc, 32'd1, 64'd65536);
    if (us != 0)
      sum += scaled_term(longint'($signed(ctl.gain_d)), err - prev, 32'd1000000, 64'(us) << 16);

    r.updated = 1'b1;
    if (sum > lim) begin
      sum       = lim;
      r.clamped = 1'b1;
    end else if (sum < -lim) begin
      sum       = -lim;
      r.clamped = 1'b1;
    end
    r.drive   = 32'(sum);
    held_meas = meas;
    return r;
  endfunction

  task automatic queue_word(logic [31:0] sp, logic [31:0] meas, logic [31:0] us, logic clr);
    sample_t w;
    w.setpoint    = sp;
    w.measurement = meas;
    w.elapsed_us  = us;
    w.clear_state = clr;
    pending_words.push_back(w);
  endtask

  // block until every queued word is sent and every result is back
  task automatic wait_drained();
    do @(negedge clk);
    while (!(pending_words.size() == 0 && !sample_valid && drive_expect.size() == 0));
  endtask

  task automatic reg_write(reg_index_t idx, logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_LOOP_ENABLE:  ctl.loop_enable  = val[0];
      REG_GAIN_P:       ctl.gain_p       = val;
      REG_GAIN_I:       ctl.gain_i       = val;
      REG_GAIN_D:       ctl.gain_d       = val;
      REG_OUTPUT_LIMIT: ctl.output_limit = val[30:0];
      default: ;
    endcase
  endtask

  task automatic load_config(logic en, logic [31:0] gp, logic [31:0] gi, logic [31:0] gd,
                             logic [30:0] lim);
    wait_drained();
    reg_write(REG_LOOP_ENABLE, {31'd0, en});
    reg_write(REG_GAIN_P, gp);
    reg_write(REG_GAIN_I, gi);
    reg_write(REG_GAIN_D, gd);
    reg_write(REG_OUTPUT_LIMIT, {1'b0, lim});
    @(negedge clk);
  endtask

  function automatic logic [31:0] gain_pick();
    case ($urandom_range(0, 3))
      0: return 32'd0;
      1: return $urandom;
      default: return $urandom_range(0, 1) ? $urandom_range(0, 32'h0008_0000)
                                            : -$urandom_range(0, 32'h0008_0000);
    endcase
  endfunction

  // sender: predicts on acceptance, then holds or loads the next word
  always @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
      send_wait    <= 0;
    end else begin
      if (sample_valid && sample_ready) drive_expect.push_back(compute_step(sample));
      if (!sample_valid || sample_ready) begin
        if (send_wait != 0) begin
          sample_valid <= 1'b0;
          send_wait    <= send_wait - 1;
        end else if (pending_words.size() != 0) begin
          sample       <= pending_words.pop_front();
          sample_valid <= 1'b1;
          send_wait    <= send_burst ? 0 : $urandom_range(0, 10);
        end else begin
          sample_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: compare against the oldest prediction, then stall at random
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
      take_wait = 0;
    end else begin
      if (result_valid && result_ready) begin
        if (drive_expect.size() == 0) begin
          $error("unexpected result word: drive %0d", result.drive);
          fail_count++;
        end else begin
          head_r = drive_expect.pop_front();
          if (result.drive !== head_r.drive) begin
            $error("drive: expected %0d, got %0d", head_r.drive, result.drive);
            fail_count++;
          end
          if (result.updated !== head_r.updated) begin
            $error("updated: expected %0d, got %0d", head_r.updated, result.updated);
            fail_count++;
          end
          if (result.clamped !== head_r.clamped) begin
            $error("clamped: expected %0d, got %0d", head_r.clamped, result.clamped);
            fail_count++;
          end
        end
        take_wait = take_burst ? 0 : $urandom_range(0, 10);
      end
      if (take_wait != 0) begin
        result_ready <= 1'b0;
        take_wait--;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no handshake anywhere
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((sample_valid && sample_ready) || (result_valid && result_ready) ||
                 (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // loop still disabled out of reset
    queue_word(32'h0010_0000, 32'h0000_0000, 32'd1000, 1'b0);
    queue_word(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1);

    // moderate gains: field extremes, zero elapsed time, clear
    load_config(1'b1, 32'h0001_0000, 32'h0000_8000, 32'h0000_1999, 31'h0064_0000);
    queue_word(32'h0000_0000, 32'h0000_0000, 32'd1000, 1'b0);
    queue_word(32'h0010_0000, 32'h0000_0000, 32'd1000, 1'b0);
    queue_word(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
    queue_word(32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 1'b0);
    queue_word(32'h0001_0000, 32'h0000_8000, 32'd0, 1'b0);
    queue_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);

    // large integral gain against a small limit shuts the integrator off
    load_config(1'b1, 32'h0000_0000, 32'h0010_0000, 32'h0000_0000, 31'h0002_0000);
    repeat (5) queue_word(32'h0001_0000, 32'h0000_0000, 32'd100000, 1'b0);

    // negative integral gain always integrates: drive the integral into saturation
    load_config(1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF);
    repeat (9) queue_word(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0);

    // zero limit: gate closed and output pinned at zero
    load_config(1'b1, 32'hFFFF_0000, 32'h0000_0000, 32'h0000_0000, 31'h0000_0000);
    queue_word(32'h0001_0000, 32'h0000_0000, 32'd1000, 1'b0);
    queue_word(32'h0000_0000, 32'h0000_0000, 32'd0, 1'b0);

    // random phases: mostly a tracking plant, some raw noise words
    for (int ph = 0; ph < PHASES; ph++) begin
      case ($urandom_range(0, 3))
        0:       limit_draw = '0;
        1:       limit_draw = 31'h7FFF_FFFF;
        2:       limit_draw = 31'($urandom);
        default: limit_draw = 31'($urandom_range(0, 32'h0100_0000));
      endcase
      case (ph)
        0: load_config(1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
        1: load_config(1'b1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h0000_0000);
        default: load_config($urandom_range(0, 7) != 0, gain_pick(), gain_pick(), gain_pick(),
                             limit_draw);
      endcase
      send_burst = $urandom_range(0, 2) == 0;
      take_burst = $urandom_range(0, 2) == 0;
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (n == PHASE_WORDS / 2) begin
          // sender holds off until the block has caught up
          wait_drained();
          send_burst = $urandom_range(0, 2) == 0;
          take_burst = $urandom_range(0, 2) == 0;
        end
        if ($urandom_range(0, 4) == 0) begin
          queue_word($urandom, $urandom, $urandom, 1'($urandom_range(0, 1)));
        end else begin
          if ($urandom_range(0, 19) == 0)
            plant_target = int'($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000;
          plant_level = plant_level + (plant_target - plant_level) / 8
                      + int'($urandom_range(0, 8192)) - 4096;
          case ($urandom_range(0, 15))
            0:       elapsed_pick = 32'd0;
            1:       elapsed_pick = $urandom;
            default: elapsed_pick = $urandom_range(100, 20000);
          endcase
          queue_word(plant_target, plant_level, elapsed_pick, $urandom_range(0, 39) == 0);
        end
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/pidc_pkg.sv
hw/rtl/pidc_regs.sv
hw/rtl/pidc_mul.sv
hw/rtl/pidc_div.sv
hw/rtl/pidc_core.sv
hw/rtl/pid_controller_trapezoid_antiwindup.sv
hw/rtl/pidc_checker.sv
dv/tb_pid_controller_trapezoid_antiwindup.sv
